>>> sv/ssrq_pkg.sv
// Shared types and codes for the sector-sorted request queue.
// Used by ssrq_ctrl, ssrq_datapath and sector_sorted_request_queue; no dependencies.
package ssrq_pkg;

	// Command codes carried on s_tuser
	localparam logic [1:0] CMD_INSERT   = 2'd0;
	localparam logic [1:0] CMD_DISPATCH = 2'd1;
	localparam logic [1:0] CMD_REMOVE   = 2'd2;

	// Status codes carried on m_tuser
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture the incoming request
		logic compare;  // register the per-entry compare vectors
		logic apply;    // update the queue and write the result register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic res_free; // result register can take a new result this cycle
	} ctrl_stat_t;

endpackage

>>> sv/ssrq_ctrl.sv
// Sequencer for the sector-sorted request queue: capture, compare, update.
// Depends on ssrq_pkg.
module ssrq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  ssrq_pkg::ctrl_stat_t  stat,
	output ssrq_pkg::ctrl_cmd_t   cmd
);

	ssrq_pkg::state_t state_q;
	ssrq_pkg::state_t state_d;

	assign s_tready    = (state_q == ssrq_pkg::S_IDLE);
	assign cmd.load    = s_tvalid && (state_q == ssrq_pkg::S_IDLE);
	assign cmd.compare = (state_q == ssrq_pkg::S_CMP);
	assign cmd.apply   = (state_q == ssrq_pkg::S_UPD) && stat.res_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssrq_pkg::S_IDLE: begin
				if (s_tvalid) state_d = ssrq_pkg::S_CMP;
			end
			ssrq_pkg::S_CMP: begin
				state_d = ssrq_pkg::S_UPD;
			end
			ssrq_pkg::S_UPD: begin
				// hold until the result register frees up
				if (stat.res_free) state_d = ssrq_pkg::S_IDLE;
			end
			default: begin
				state_d = ssrq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssrq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/ssrq_datapath.sv
// Entry row, compare vectors, shift update and result register of the queue.
// Depends on ssrq_pkg; driven by ssrq_ctrl.
module ssrq_datapath #(
	parameter int DEPTH       = 16,
	parameter int SECTOR_BITS = 48,
	parameter int ID_BITS     = 8,
	parameter int CNT_BITS    = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssrq_pkg::ctrl_cmd_t   cmd,
	output ssrq_pkg::ctrl_stat_t  stat,
	input  logic [1:0]            in_cmd,
	input  logic [ID_BITS-1:0]    in_id,
	input  logic [SECTOR_BITS-1:0] in_sec,
	input  logic                  m_tready,
	output logic                  res_valid,
	output logic [1:0]            res_status,
	output logic [ID_BITS-1:0]    res_id,
	output logic [SECTOR_BITS-1:0] res_sec,
	output logic [CNT_BITS-1:0]   res_cnt
);

	localparam int LEVELS = $clog2(DEPTH);

	logic [SECTOR_BITS-1:0] key_q [DEPTH];
	logic [ID_BITS-1:0]     id_q  [DEPTH];
	logic [SECTOR_BITS-1:0] key_d [DEPTH];
	logic [ID_BITS-1:0]     id_d  [DEPTH];
	logic [CNT_BITS-1:0]    fill_q;
	logic [CNT_BITS-1:0]    fill_d;

	logic [1:0]             cmd_q;
	logic [ID_BITS-1:0]     rid_q;
	logic [SECTOR_BITS-1:0] sec_q;

	logic [DEPTH-1:0]       gt_q;
	logic [DEPTH-1:0]       match_q;
	logic [DEPTH-1:0]       gt_d;
	logic [DEPTH-1:0]       match_d;
	logic [DEPTH-1:0]       pfx [LEVELS+1];
	logic [DEPTH-1:0]       ins_at;
	logic [DEPTH-1:0]       up_mask;

	logic                   is_full;
	logic                   is_empty;
	logic                   found;
	logic                   do_ins;
	logic                   do_disp;
	logic                   do_rm;
	logic [1:0]             status_d;

	logic                   res_valid_q;
	logic [1:0]             res_status_q;
	logic [ID_BITS-1:0]     res_id_q;
	logic [SECTOR_BITS-1:0] res_sec_q;
	logic [CNT_BITS-1:0]    res_cnt_q;

	// Per-entry compares; entries at or beyond the fill count never hit
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt_d[i]    = (CNT_BITS'(i) < fill_q) && (key_q[i] > sec_q);
			match_d[i] = (CNT_BITS'(i) < fill_q) && (id_q[i] == rid_q);
		end
	end

	// Prefix OR of the id hits: every entry from the first hit onward moves up
	always_comb begin
		pfx[0] = match_q;
		for (int lv = 0; lv < LEVELS; lv++) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (i >= (1 << lv)) begin
					pfx[lv+1][i] = pfx[lv][i] | pfx[lv][i - (1 << lv)];
				end else begin
					pfx[lv+1][i] = pfx[lv][i];
				end
			end
		end
	end

	assign is_full  = (fill_q == CNT_BITS'(DEPTH));
	assign is_empty = (fill_q == '0);
	assign found    = pfx[LEVELS][DEPTH-1];
	assign do_ins   = (cmd_q == ssrq_pkg::CMD_INSERT) && !is_full;
	assign do_disp  = (cmd_q == ssrq_pkg::CMD_DISPATCH) && !is_empty;
	assign do_rm    = (cmd_q == ssrq_pkg::CMD_REMOVE) && found;

	// gt_q is a thermometer over the sorted entries: the new request lands at its edge
	always_comb begin
		ins_at[0] = gt_q[0] || (fill_q == '0);
		for (int i = 1; i < DEPTH; i++) begin
			ins_at[i] = !gt_q[i-1] && (gt_q[i] || (fill_q == CNT_BITS'(i)));
		end
	end

	assign up_mask = do_disp ? '1 : (do_rm ? pfx[LEVELS] : '0);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			key_d[i] = key_q[i];
			id_d[i]  = id_q[i];
		end
		if (do_ins) begin
			for (int i = 1; i < DEPTH; i++) begin
				if (gt_q[i-1]) begin
					key_d[i] = key_q[i-1];
					id_d[i]  = id_q[i-1];
				end
			end
			for (int i = 0; i < DEPTH; i++) begin
				if (ins_at[i]) begin
					key_d[i] = sec_q;
					id_d[i]  = rid_q;
				end
			end
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (up_mask[i]) begin
				key_d[i] = key_q[i+1];
				id_d[i]  = id_q[i+1];
			end
		end
	end

	always_comb begin
		fill_d = fill_q;
		if (do_ins) begin
			fill_d = fill_q + CNT_BITS'(1);
		end else if (do_disp || do_rm) begin
			fill_d = fill_q - CNT_BITS'(1);
		end
	end

	always_comb begin
		case (cmd_q)
			ssrq_pkg::CMD_INSERT:   status_d = is_full ? ssrq_pkg::ST_FULL : ssrq_pkg::ST_OK;
			ssrq_pkg::CMD_DISPATCH: status_d = is_empty ? ssrq_pkg::ST_EMPTY : ssrq_pkg::ST_OK;
			ssrq_pkg::CMD_REMOVE:   status_d = found ? ssrq_pkg::ST_OK : ssrq_pkg::ST_MISSING;
			default:                status_d = ssrq_pkg::ST_OK;
		endcase
	end

	// Request capture and compare vectors
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			rid_q <= in_id;
			sec_q <= in_sec;
		end
		if (cmd.compare) begin
			gt_q    <= gt_d;
			match_q <= match_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < DEPTH; i++) begin
				key_q[i] <= key_d[i];
				id_q[i]  <= id_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.apply) begin
			fill_q <= fill_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			res_status_q <= status_d;
			res_id_q     <= do_disp ? id_q[0] : '0;
			res_sec_q    <= do_disp ? key_q[0] : '0;
			res_cnt_q    <= fill_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign stat.res_free = !res_valid_q || m_tready;
	assign res_valid     = res_valid_q;
	assign res_status    = res_status_q;
	assign res_id        = res_id_q;
	assign res_sec       = res_sec_q;
	assign res_cnt       = res_cnt_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(DEPTH))
		else $error("fill count beyond queue depth");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q >= CNT_BITS'(2)) |-> (key_q[0] <= key_q[1]))
		else $error("head entries out of sector order");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && is_full && (cmd_q == ssrq_pkg::CMD_INSERT))
		|=> (fill_q == $past(fill_q)) && (res_status_q == ssrq_pkg::ST_FULL))
		else $error("insert into full queue changed the fill count");

endmodule

>>> sv/sector_sorted_request_queue.sv
// Top level of the sector-sorted request queue: stream ports, controller and datapath.
// Depends on ssrq_pkg, ssrq_ctrl and ssrq_datapath.
//
// Disk request queue kept in ascending order of end sector. Each request on the slave
// stream carries a command on s_tuser: insert places (request_id, sector) ahead of the
// first queued entry with a strictly greater sector, so equal sectors keep arrival
// order; dispatch pops the head (smallest sector) and reports its id and sector; remove
// deletes the queued entry with the given id nearest the head. Every request yields
// exactly one result on the master stream with a status on m_tuser (ok, full and the
// insert dropped, empty, id not found) and the entry count after the command; out_id
// and out_sector are zero unless a dispatch succeeded. Unused command codes leave the
// queue alone and report ok. Each request passes through three steps: a capture step, a
// compare step in which every entry compares its sector and id against it in parallel, and
// an update step in which the entry row shifts in place. The result register sits between
// the two streams, so a new request is accepted while an earlier result still waits; a
// request only stalls in its update step when that result has not yet been taken.
module sector_sorted_request_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int SECTOR_BITS = 48,
	parameter int ID_BITS     = 8,
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1),
	localparam int IN_BITS  = ID_BITS + SECTOR_BITS,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ID_BITS + SECTOR_BITS + CNT_BITS,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// request_id, sector
	input  logic [IN_W-1:0]                      s_tdata,
	// command
	input  logic [1:0]                           s_tuser,

	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_id, out_sector, entries, zero padding
	output logic [OUT_W-1:0]                     m_tdata,
	// status
	output logic [1:0]                           m_tuser
);

	ssrq_pkg::ctrl_cmd_t  cmd;
	ssrq_pkg::ctrl_stat_t stat;

	logic [ID_BITS-1:0]     res_id;
	logic [SECTOR_BITS-1:0] res_sec;
	logic [CNT_BITS-1:0]    res_cnt;

	// Sequence each request: capture, compare, update
	ssrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the sorted entry row and the result register
	ssrq_datapath #(
		.DEPTH       (QUEUE_DEPTH),
		.SECTOR_BITS (SECTOR_BITS),
		.ID_BITS     (ID_BITS),
		.CNT_BITS    (CNT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_cmd     (s_tuser),
		.in_id      (s_tdata[ID_BITS-1:0]),
		.in_sec     (s_tdata[ID_BITS +: SECTOR_BITS]),
		.m_tready   (m_tready),
		.res_valid  (m_tvalid),
		.res_status (m_tuser),
		.res_id     (res_id),
		.res_sec    (res_sec),
		.res_cnt    (res_cnt)
	);

	// Pack the result, id lowest, zero padding on top
	assign m_tdata = OUT_W'({res_cnt, res_sec, res_id});

endmodule

>>> bench/tb_top.sv
// Self-checking bench for sector_sorted_request_queue: directed, fill, backpressure and random tests.
// Depends on ssrq_pkg and the sector_sorted_request_queue RTL; predicts each result in-bench.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	localparam int SECTOR_BITS = 48;
	localparam int ID_BITS     = 8;
	localparam int IN_W        = 56;  // id + sector, padded to whole bytes
	localparam int OUT_W       = 64;  // id + sector + entries, padded to whole bytes
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [SECTOR_BITS-1:0] SECTOR_MAX = '1;
	localparam int LONG_STALL  = 250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic [SECTOR_BITS-1:0] sector;
		logic [ID_BITS-1:0]     id;
	} queued_req_t;

	typedef struct {
		logic [1:0]             status;
		logic [ID_BITS-1:0]     out_id;
		logic [SECTOR_BITS-1:0] out_sector;
		logic [4:0]             entries;
	} queue_result_t;

	logic clk;
	logic arst_n;

	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // request_id, sector
	logic [1:0]       s_tuser;   // command
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // out_id, out_sector, entries, zero padding
	logic [1:0]       m_tuser;   // status

	// Bench copy of the sorted queue, head at index 0
	queued_req_t   queued_reqs[$];
	// Results predicted for accepted requests, oldest first
	queue_result_t expected_results[$];

	bit src_gaps_on;
	bit sink_stalls_on;
	bit long_stall_req;
	int error_count;
	int cycle_count;
	int n_insert, n_dispatch, n_remove, n_unused;
	int n_full, n_empty, n_missing, n_checked, max_fill;

	sector_sorted_request_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.SECTOR_BITS(SECTOR_BITS),
		.ID_BITS(ID_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[sector_sorted_request_queue] ERROR");
			$finish;
		end
	end

	// Apply one request to the bench queue and return the result it must produce.
	function automatic queue_result_t predict_queue_result(logic [1:0] cmd,
			logic [ID_BITS-1:0] rid, logic [SECTOR_BITS-1:0] sec);
		queue_result_t r;
		queued_req_t   e;
		int            pos;
		r.status     = ssrq_pkg::ST_OK;
		r.out_id     = '0;
		r.out_sector = '0;
		case (cmd)
			ssrq_pkg::CMD_INSERT: begin
				n_insert++;
				if (queued_reqs.size() >= QUEUE_DEPTH) begin
					r.status = ssrq_pkg::ST_FULL;
					n_full++;
				end else begin
					// land ahead of the first strictly greater sector; ties keep arrival order
					pos = queued_reqs.size();
					for (int i = 0; i < queued_reqs.size(); i++) begin
						if (queued_reqs[i].sector > sec) begin
							pos = i;
							break;
						end
					end
					e.sector = sec;
					e.id     = rid;
					queued_reqs.insert(pos, e);
				end
			end
			ssrq_pkg::CMD_DISPATCH: begin
				n_dispatch++;
				if (queued_reqs.size() == 0) begin
					r.status = ssrq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					e = queued_reqs.pop_front();
					r.out_id     = e.id;
					r.out_sector = e.sector;
				end
			end
			ssrq_pkg::CMD_REMOVE: begin
				n_remove++;
				r.status = ssrq_pkg::ST_MISSING;
				// only the match nearest the head goes
				for (int i = 0; i < queued_reqs.size(); i++) begin
					if (queued_reqs[i].id == rid) begin
						queued_reqs.delete(i);
						r.status = ssrq_pkg::ST_OK;
						break;
					end
				end
				if (r.status == ssrq_pkg::ST_MISSING)
					n_missing++;
			end
			default: begin
				n_unused++;
			end
		endcase
		r.entries = 5'(queued_reqs.size());
		if (queued_reqs.size() > max_fill)
			max_fill = queued_reqs.size();
		return r;
	endfunction

	// Offer one request, optionally after a random gap; return at the edge it is taken.
	// Must be entered at a rising edge. tvalid stays high afterwards for back-to-back requests.
	task automatic send_request(input logic [1:0] cmd, input logic [ID_BITS-1:0] rid,
			input logic [SECTOR_BITS-1:0] sec);
		if (src_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= IN_W'({sec, rid});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_results.push_back(predict_queue_result(cmd, rid, sec));
	endtask

	// Hold the source idle until every outstanding request has been answered.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	function automatic logic [SECTOR_BITS-1:0] random_sector();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return '0;
			1: return SECTOR_MAX;
			2, 3, 4: return SECTOR_BITS'($urandom_range(0, 15));  // force ties
			default: return SECTOR_BITS'({$urandom, $urandom});
		endcase
	endfunction

	// Edge cases on a fresh queue
	task automatic test_directed_cases();
		send_request(ssrq_pkg::CMD_DISPATCH, 8'hA5, SECTOR_MAX);    // dispatch while empty
		send_request(ssrq_pkg::CMD_REMOVE, 8'h00, '0);              // remove while empty
		send_request(ssrq_pkg::CMD_INSERT, 8'hFF, SECTOR_MAX);
		send_request(ssrq_pkg::CMD_INSERT, 8'h00, '0);
		send_request(ssrq_pkg::CMD_INSERT, 8'h11, 48'h5555_5555_5555);
		send_request(ssrq_pkg::CMD_INSERT, 8'h12, 48'h5555_5555_5555);  // equal sector, behind
		send_request(ssrq_pkg::CMD_INSERT, 8'h13, 48'hAAAA_AAAA_AAAA);
		send_request(ssrq_pkg::CMD_INSERT, 8'h11, 48'h0000_0000_0001);  // duplicate id, nearer head
		send_request(ssrq_pkg::CMD_REMOVE, 8'h11, '0);              // drops the one nearest the head
		send_request(ssrq_pkg::CMD_REMOVE, 8'h77, '0);              // absent id
		send_request(CMD_UNUSED, 8'hFF, SECTOR_MAX);                // unused command, no change
		send_request(CMD_UNUSED, 8'h00, '0);
		repeat (6)
			send_request(ssrq_pkg::CMD_DISPATCH, 8'h00, '0);        // empty it, then one too many
		drain_results();
	endtask

	// Fill to capacity, overflow, and empty it again
	task automatic test_full_queue();
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_request(ssrq_pkg::CMD_INSERT, ID_BITS'($urandom), random_sector());
		send_request(ssrq_pkg::CMD_INSERT, 8'hEE, '0);              // dropped
		send_request(ssrq_pkg::CMD_INSERT, 8'hEF, SECTOR_MAX);      // dropped
		send_request(ssrq_pkg::CMD_REMOVE, queued_reqs[QUEUE_DEPTH-1].id, '0);
		send_request(ssrq_pkg::CMD_INSERT, 8'hF0, 48'h8000_0000_0000);
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_request(ssrq_pkg::CMD_DISPATCH, ID_BITS'($urandom),
				SECTOR_BITS'({$urandom, $urandom}));
		drain_results();
	endtask

	// Hold the receiver off for a long stretch while the source keeps pushing
	task automatic test_sink_backpressure();
		bit saved_gaps;
		saved_gaps  = src_gaps_on;
		src_gaps_on = 1'b0;
		long_stall_req = 1'b1;
		for (int i = 0; i < 30; i++) begin
			if (i % 3 == 2)
				send_request(ssrq_pkg::CMD_DISPATCH, '0, '0);
			else
				send_request(ssrq_pkg::CMD_INSERT, ID_BITS'($urandom), random_sector());
		end
		src_gaps_on = saved_gaps;
		drain_results();
	endtask

	// Mixed traffic in blocks that lean toward filling, draining or neither
	task automatic test_random_traffic(input int n_blocks, input int block_len);
		int mode;
		int roll;
		int ins_lim, dsp_lim, rem_lim;
		logic [ID_BITS-1:0] rid;
		for (int b = 0; b < n_blocks; b++) begin
			mode = $urandom_range(0, 2);
			case (mode)
				0: begin ins_lim = 70; dsp_lim = 85; rem_lim = 97; end  // fill-heavy
				1: begin ins_lim = 25; dsp_lim = 75; rem_lim = 97; end  // drain-heavy
				default: begin ins_lim = 45; dsp_lim = 78; rem_lim = 96; end
			endcase
			for (int i = 0; i < block_len; i++) begin
				roll = $urandom_range(0, 99);
				rid  = ID_BITS'($urandom);
				if (roll < ins_lim) begin
					// reuse a queued id now and then to build duplicates
					if (queued_reqs.size() != 0 && $urandom_range(0, 7) == 0)
						rid = queued_reqs[$urandom_range(0, queued_reqs.size() - 1)].id;
					send_request(ssrq_pkg::CMD_INSERT, rid, random_sector());
				end else if (roll < dsp_lim) begin
					send_request(ssrq_pkg::CMD_DISPATCH, rid,
						SECTOR_BITS'({$urandom, $urandom}));
				end else if (roll < rem_lim) begin
					if (queued_reqs.size() != 0 && $urandom_range(0, 3) != 0)
						rid = queued_reqs[$urandom_range(0, queued_reqs.size() - 1)].id;
					send_request(ssrq_pkg::CMD_REMOVE, rid, SECTOR_BITS'({$urandom, $urandom}));
				end else begin
					send_request(CMD_UNUSED, rid, SECTOR_BITS'({$urandom, $urandom}));
				end
			end
			// pause the source until the block is fully answered, now and then
			if (src_gaps_on && $urandom_range(0, 4) == 0)
				drain_results();
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				m_tready <= 1'b1;
			end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker: compare each accepted result against the oldest prediction
	always @(posedge clk) begin
		queue_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d id %0h sector %0h entries %0d",
					m_tuser, m_tdata[7:0], m_tdata[55:8], m_tdata[60:56]);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				n_checked++;
				if (m_tuser !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
					error_count++;
				end
				if (m_tdata[7:0] !== exp_r.out_id) begin
					$error("out_id: expected %0h, actual %0h", exp_r.out_id, m_tdata[7:0]);
					error_count++;
				end
				if (m_tdata[55:8] !== exp_r.out_sector) begin
					$error("out_sector: expected %0h, actual %0h",
						exp_r.out_sector, m_tdata[55:8]);
					error_count++;
				end
				if (m_tdata[60:56] !== exp_r.entries) begin
					$error("entries: expected %0d, actual %0d", exp_r.entries, m_tdata[60:56]);
					error_count++;
				end
			end
		end
	end

	initial begin
		int settle;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ssrq_pkg::CMD_INSERT;
		src_gaps_on    = 1'b1;
		sink_stalls_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_queue();
		test_sink_backpressure();
		test_random_traffic(18, 40);
		// closing stretch at full rate on both sides
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		test_random_traffic(4, 40);

		drain_results();
		settle = 0;
		while (settle < SETTLE_CYCLES) begin
			@(posedge clk);
			settle++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			error_count++;
		end

		$display("requests: %0d insert (%0d dropped full), %0d dispatch (%0d empty)",
			n_insert, n_full, n_dispatch, n_empty);
		$display("          %0d remove (%0d missing), %0d unused; peak fill %0d, %0d checked",
			n_remove, n_missing, n_unused, max_fill, n_checked);
		if (error_count == 0)
			$display("[sector_sorted_request_queue] OK");
		else
			$display("[sector_sorted_request_queue] ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/ssrq_pkg.sv
sv/ssrq_ctrl.sv
sv/ssrq_datapath.sv
sv/sector_sorted_request_queue.sv
bench/tb_top.sv
